/* src/r250_pkg.sv */
// Shared types, constants and the power-up table of the R250 generator.
`default_nettype none
package r250_pkg;

    localparam int unsigned RingLen = 250;
    localparam int unsigned AddrW = 8;
    localparam int unsigned WordW = 16;
    localparam logic [AddrW-1:0] FarLag = 8'd103;
    localparam logic [AddrW-1:0] WrapPoint = 8'd147;
    localparam logic [AddrW-1:0] LastPos = 8'd249;
    localparam logic [AddrW-1:0] DiagFirst = 8'd3;
    localparam logic [AddrW-1:0] DiagStep = 8'd11;
    localparam logic [31:0] LcgMul = 32'h015A_4E35;
    localparam logic [14:0] TopLimit = 15'h4001;

    localparam logic CmdReseed = 1'b0;
    localparam logic CmdDraw = 1'b1;

    function automatic logic [31:0] lcg_jump_mul();
        logic [31:0] a;
        a = 32'd1;
        for (int i = 0; i < RingLen; i++) begin
            a = a * LcgMul;
        end
        return a;
    endfunction

    function automatic logic [31:0] lcg_jump_add();
        logic [31:0] c;
        c = 32'd0;
        for (int i = 0; i < RingLen; i++) begin
            c = c * LcgMul + 32'd1;
        end
        return c;
    endfunction

    localparam logic [31:0] JumpMul = lcg_jump_mul();
    localparam logic [31:0] JumpAdd = lcg_jump_add();

    typedef struct packed {
        logic             en;
        logic [AddrW-1:0] addr_a;
        logic [AddrW-1:0] addr_b;
    } t_store_rd;

    typedef struct packed {
        logic             en;
        logic [AddrW-1:0] addr;
        logic [WordW-1:0] data;
    } t_store_wr;

    typedef struct packed {
        logic             start;
        logic             step;
        logic [WordW-1:0] seed;
    } t_lcg_ctl;

    localparam logic [WordW-1:0] InitTable [RingLen] = '{
        16'd15301,  -16'd7772,  16'd10921,  -16'd9191,  16'd19316,
        -16'd22382, -16'd10809, -16'd16284, 16'd32360,
        -16'd15954, 16'd26124,  16'd25833,  -16'd31132, 16'd11030,
        16'd26232,  16'd13965,  16'd16051,  -16'd1901,
        -16'd9676,  16'd5184,   16'd15931,  -16'd25754, 16'd16845,
        16'd11371,  -16'd26912, 16'd10328,  16'd9139,
        16'd1684,   -16'd16868, -16'd6148,  16'd13297,  16'd1364,
        -16'd9508,  16'd15687,  -16'd2257,  16'd27771,
        16'd5277,   -16'd20908, 16'd31973,  -16'd18559, 16'd16327,
        16'd23408,  -16'd29471, -16'd13264, -16'd31926,
        -16'd3987,  -16'd7172,  16'd3472,   16'd21367,  -16'd9179,
        -16'd9191,  -16'd11501, 16'd7712,   -16'd9652,
        -16'd25762, 16'd10241,  -16'd15372, -16'd17541, 16'd1718,
        -16'd18649, -16'd17644, 16'd6010,   16'd29575,
        -16'd10564, 16'd30458,  16'd21966,  -16'd11087, 16'd10387,
        16'd4492,   16'd644,    -16'd8505,  -16'd23929,
        -16'd3716,  -16'd10948, -16'd24687, -16'd11484, -16'd5661,
        -16'd22408, -16'd15166, -16'd20845, 16'd286,
        16'd12071,  16'd3574,   -16'd4152,  16'd15592,  -16'd19859,
        16'd9711,   16'd23022,  -16'd30280, -16'd20043,
        -16'd16623, 16'd146,    16'd9053,   16'd5881,   -16'd28901,
        -16'd22256, -16'd12072, 16'd8529,   -16'd31192,
        -16'd581,   -16'd27270, 16'd12730,  16'd101,    16'd16208,
        16'd12607,  -16'd6615,  16'd22036,  16'd8221,
        16'd31337,  16'd11984,  16'd20290,  16'd26734,  16'd19552,
        16'd48,     16'd31940,  -16'd22088, -16'd30774,
        -16'd12192, -16'd4872,  16'd12809,  -16'd8218,  16'd17436,
        -16'd20806, 16'd19375,  16'd30,     16'd17425,
        16'd14117,  16'd5416,   16'd23853,  -16'd9753,  -16'd7541,
        16'd32074,  16'd26526,  16'd2192,   16'd11447,
        16'd11,     -16'd12090, -16'd30384, -16'd926,   -16'd653,
        16'd26899,  16'd25357,  16'd7667,   16'd3577,
        -16'd26122, -16'd14375, 16'd4,      -16'd7109,  -16'd8194,
        -16'd6979,  -16'd12303, 16'd1066,   16'd29237,
        -16'd28728, 16'd19370,  16'd17493,  -16'd27968, 16'd3,
        -16'd4068,  -16'd26660, 16'd17586,  -16'd599,
        16'd21716,  -16'd9064,  -16'd7376,  -16'd20581, -16'd10315,
        -16'd1656,  16'd1,      16'd32200,  -16'd3470,
        16'd22911,  16'd24090,  16'd10438,  -16'd24753, -16'd29172,
        16'd14999,  16'd2489,   -16'd22252, 16'd9898,
        -16'd25924, 16'd9245,   16'd593,    -16'd30679, -16'd24482,
        16'd30162,  -16'd39,    -16'd12196, 16'd27209,
        -16'd20119, -16'd28039, 16'd4612,   -16'd7139,  -16'd12626,
        -16'd9223,  -16'd2820,  16'd22377,  -16'd25226,
        16'd15190,  -16'd31065, -16'd1531,  16'd18090,  16'd11326,
        -16'd14697, -16'd2635,  -16'd6252,  16'd5580,
        16'd15231,  16'd9467,   16'd13161,  -16'd7036,  16'd7259,
        16'd317,    -16'd14568, 16'd2962,   16'd23006,
        16'd32280,  16'd6994,   16'd18751,  16'd5148,   -16'd12797,
        -16'd16166, -16'd13644, 16'd18552,  -16'd13272,
        -16'd11505, 16'd2804,   16'd17360,  16'd1919,   16'd19639,
        16'd2323,   16'd9448,   -16'd21715, 16'd11022,
        -16'd20036, 16'd31509,  -16'd16356, -16'd29938, -16'd26653,
        16'd19754,  16'd987,    16'd11521,  -16'd10042,
        -16'd27480, 16'd20664,  16'd2629,   -16'd14550, 16'd31009,
        -16'd11493, -16'd5793
    };

endpackage
`default_nettype wire

/* src/r250_store.sv */
// Feedback word store: two read ports, one write port, power-up table behind valid bits.
`default_nettype none
module r250_store (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire r250_pkg::t_store_rd i_rd,
    input  wire r250_pkg::t_store_wr i_wr,
    output logic [15:0]             o_data_a,
    output logic [15:0]             o_data_b
);
    import r250_pkg::*;

    logic [WordW-1:0]   mem [RingLen];
    logic [RingLen-1:0] r_valid;
    logic [WordW-1:0]   r_mem_a;
    logic [WordW-1:0]   r_mem_b;
    logic [WordW-1:0]   r_tab_a;
    logic [WordW-1:0]   r_tab_b;
    logic               r_vld_a;
    logic               r_vld_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_mem_a <= mem[i_rd.addr_a];
            r_mem_b <= mem[i_rd.addr_b];
            r_tab_a <= InitTable[i_rd.addr_a];
            r_tab_b <= InitTable[i_rd.addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_vld_a <= r_valid[i_rd.addr_a];
                r_vld_b <= r_valid[i_rd.addr_b];
            end
        end
    end

    assign o_data_a = r_vld_a ? r_mem_a : r_tab_a;
    assign o_data_b = r_vld_b ? r_mem_b : r_tab_b;

endmodule
`default_nettype wire

/* src/r250_lcg.sv */
// Paired LCG streams 250 steps apart that build the reseed words.
`default_nettype none
module r250_lcg (
    input  wire logic               i_clk,
    input  wire r250_pkg::t_lcg_ctl i_ctl,
    output logic [15:0]             o_fill_word
);
    import r250_pkg::*;

    logic [31:0] r_lo;
    logic [31:0] r_hi;
    logic [31:0] n_lo;
    logic [31:0] n_hi;
    logic [31:0] start_hi;

    assign n_lo = r_lo * LcgMul + 32'd1;
    assign n_hi = r_hi * LcgMul + 32'd1;
    assign start_hi = JumpMul * {16'd0, i_ctl.seed} + JumpAdd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_lo <= {16'd0, i_ctl.seed};
            r_hi <= start_hi;
        end else if (i_ctl.step) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    assign o_fill_word = {(n_hi[30:16] >= TopLimit), n_lo[30:16]};

endmodule
`default_nettype wire

/* src/r250_random_generator.sv */
// Top level of the R250 XOR-feedback random word generator.
// Input stream: tuser carries the command (0 reseed, 1 draw), tdata the 16-bit seed.
// Output stream: tdata carries one 16-bit random word for every draw; a reseed
// produces no output beat.
// A draw reads the store at both taps on the accept edge; in the draw state, once the
// output register is free, the XOR is written back and registered into the output.
// A new input beat is taken only after that word has entered the output register.
// A reseed holds tready low while all 250 store words are rewritten: one store write per
// cycle, both LCG streams advancing together, diagonal words patched in flight.
// When the receiver stalls, the output register holds its beat; the next draw is
// still accepted and its result waits in the read stage until the output frees.
// Reset returns the ring position to zero and makes every store word read as the
// power-up table again; no clearing pass is needed and the block is ready at once.
`default_nettype none
module r250_random_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // [15:0] seed_value
    input  wire logic        i_s_axis_tuser,  // [0] cmd
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata   // [15:0] random_word
);
    import r250_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAW,
        S_FILL
    } t_state;

    t_state           r_state;
    logic [AddrW-1:0] r_pos;
    logic [AddrW-1:0] r_fill_idx;
    logic [AddrW-1:0] r_diag_pos;
    logic [4:0]       r_diag_k;
    logic             r_out_valid;
    logic [WordW-1:0] r_out_data;

    t_store_rd        rd;
    t_store_wr        wr;
    t_lcg_ctl         lcg_ctl;
    logic [WordW-1:0] data_a;
    logic [WordW-1:0] data_b;
    logic [WordW-1:0] fill_word;
    logic [WordW-1:0] fill_data;
    logic [AddrW-1:0] partner;
    logic             accept;
    logic             out_free;
    logic             diag_hit;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign partner = (r_pos >= WrapPoint) ? r_pos - WrapPoint : r_pos + FarLag;
    assign diag_hit = !r_diag_k[4] && (r_fill_idx == r_diag_pos);

    always_comb begin
        fill_data = fill_word;
        if (diag_hit) begin
            fill_data = (fill_word & (16'hFFFF >> r_diag_k[3:0]))
                      | (16'h8000 >> r_diag_k[3:0]);
        end
    end

    always_comb begin
        rd.en = accept && (i_s_axis_tuser == CmdDraw);
        rd.addr_a = r_pos;
        rd.addr_b = partner;
        lcg_ctl.start = accept && (i_s_axis_tuser == CmdReseed);
        lcg_ctl.step = (r_state == S_FILL);
        lcg_ctl.seed = i_s_axis_tdata;
        wr.en = 1'b0;
        wr.addr = r_pos;
        wr.data = data_a ^ data_b;
        unique case (r_state)
            S_IDLE: begin
                wr.en = 1'b0;
            end
            S_DRAW: begin
                wr.en = out_free;
            end
            S_FILL: begin
                wr.en = 1'b1;
                wr.addr = r_fill_idx;
                wr.data = fill_data;
            end
            default: begin
                wr.en = 1'b0;
            end
        endcase
    end

    r250_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (rd),
        .i_wr     (wr),
        .o_data_a (data_a),
        .o_data_b (data_b)
    );

    r250_lcg u_lcg (
        .i_clk       (i_clk),
        .i_ctl       (lcg_ctl),
        .o_fill_word (fill_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos <= '0;
            r_fill_idx <= '0;
            r_diag_pos <= DiagFirst;
            r_diag_k <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && (r_state != S_DRAW)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_s_axis_tuser == CmdDraw) begin
                            r_state <= S_DRAW;
                        end else begin
                            r_state <= S_FILL;
                            r_fill_idx <= '0;
                            r_diag_pos <= DiagFirst;
                            r_diag_k <= '0;
                        end
                    end
                end
                S_DRAW: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data <= data_a ^ data_b;
                        r_pos <= (r_pos == LastPos) ? '0 : r_pos + 8'd1;
                        r_state <= S_IDLE;
                    end
                end
                S_FILL: begin
                    if (diag_hit) begin
                        r_diag_k <= r_diag_k + 5'd1;
                        r_diag_pos <= r_diag_pos + DiagStep;
                    end
                    r_fill_idx <= r_fill_idx + 8'd1;
                    if (r_fill_idx == LastPos) begin
                        r_pos <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = r_out_data;

endmodule
`default_nettype wire
